@@ rtl/core/mob_pkg.sv @@
package mob_pkg;

	localparam int HIDDEN_UNITS_DEF = 128;
	localparam int SIG_ENTRIES      = 256;
	localparam int IDX_W            = 9;
	localparam int STEP_W           = 24;
	localparam logic [STEP_W-1:0] STEP_RESET = 24'd838861;

	// sigmoid domain limits, Q16.24 on the 40-bit pre-activation
	localparam logic signed [39:0] SIG_LO = -40'sd134217728;
	localparam logic signed [39:0] SIG_HI = 40'sd134217728;
	localparam logic [24:0] ONE_Q24 = 25'd16777216;

	typedef longint unsigned u64_t;

	typedef enum logic [1:0] {
		REQ_INFER = 2'd0,
		REQ_TRAIN = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_READ  = 2'd3
	} req_op_t;

	// datapath commands, one per cycle
	typedef enum logic [4:0] {
		OP_NOP,
		OP_CLEAR,
		OP_LOAD,
		OP_WRITE,
		OP_RD_ADDR,
		OP_RD_TAKE,
		OP_MUL_W0L,
		OP_MUL_W1R,
		OP_ADD_P,
		OP_SIG_IDX,
		OP_MUL_INTERP,
		OP_SIG_OUT,
		OP_MUL_HV,
		OP_ACC,
		OP_FWD_DONE,
		OP_MUL_EH,
		OP_TAKE,
		OP_MUL_TLR,
		OP_UPD_V,
		OP_MUL_DERIV,
		OP_MUL_EV,
		OP_TAKE_A,
		OP_MUL_AD,
		OP_MUL_CL,
		OP_UPD_W0,
		OP_UPD_W1,
		OP_FINISH
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_RD_ADDR,
		ST_RD_TAKE,
		ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8,
		ST_FWD_DONE,
		ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_T6, ST_T7,
		ST_T8, ST_T9, ST_T10, ST_T11, ST_T12, ST_T13, ST_T14,
		ST_FINISH
	} ctl_state_t;

	typedef enum logic [1:0] {
		WS_NONE,
		WS_W0,
		WS_W1,
		WS_V
	} wsel_t;

	typedef logic [24:0] sig_tab_t [SIG_ENTRIES+1];

	// shift-subtract divide, elaboration only
	function automatic u64_t udiv(input u64_t n, input u64_t d);
		u64_t q;
		u64_t r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// e^-f in Q30, 0 <= f <= 1.0
	function automatic u64_t exp_neg_q30(input u64_t f);
		u64_t term;
		u64_t pos;
		u64_t neg;
		term = u64_t'(1) << 30;
		pos  = u64_t'(1) << 30;
		neg  = '0;
		for (int n = 1; n <= 20; n++) begin
			term = udiv((term * f) >> 30, u64_t'(n));
			if (n % 2 == 1) neg = neg + term;
			else pos = pos + term;
		end
		return (pos > neg) ? pos - neg : u64_t'(0);
	endfunction

	function automatic logic [24:0] sig_point(input longint x);
		u64_t m;
		u64_t y;
		u64_t d;
		u64_t s;
		m = (x < 0) ? u64_t'(-x) : u64_t'(x);
		y = exp_neg_q30(m * 8);
		for (int i = 0; i < 3; i++) begin
			y = (y * y) >> 30;
		end
		d = (u64_t'(1) << 30) + y;
		s = udiv((u64_t'(1) << 54) + (d >> 1), d);
		return (x < 0) ? 25'((u64_t'(1) << 24) - s) : 25'(s);
	endfunction

	function automatic sig_tab_t build_sig_tab();
		sig_tab_t t;
		longint x;
		for (int k = 0; k <= SIG_ENTRIES; k++) begin
			x = -longint'(134217728) + ((longint'(k) << 28) / SIG_ENTRIES);
			t[k] = sig_point(x);
		end
		return t;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'sd2147483647) return 32'sh7fffffff;
		if (v < -48'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

@@ rtl/core/mob_if.sv @@
interface mob_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] left_operand;
	logic signed [31:0] right_operand;
	logic signed [31:0] target_sum;
	logic [8:0]         weight_index;
	logic signed [31:0] weight_value;

	modport source (
		output valid, operation, left_operand, right_operand, target_sum,
		       weight_index, weight_value,
		input  ready
	);
	modport sink (
		input  valid, operation, left_operand, right_operand, target_sum,
		       weight_index, weight_value,
		output ready
	);
endinterface

interface mob_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] network_output;
	logic signed [31:0] weight_data;

	modport source (output valid, network_output, weight_data, input ready);
	modport sink (input valid, network_output, weight_data, output ready);
endinterface

@@ rtl/core/mob_ram.sv @@
module mob_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/mob_ctrl.sv @@
module mob_ctrl #(
	parameter int HIDDEN_UNITS = mob_pkg::HIDDEN_UNITS_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               req_valid,
	input  logic [1:0]                                         req_op,
	input  logic                                               rsp_ready,
	output logic                                               req_ready,
	output logic                                               rsp_valid,
	output mob_pkg::dp_op_t                                    cmd,
	output logic [((HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1)-1:0] addr
);

	localparam int AW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam logic [AW-1:0] LAST = AW'(HIDDEN_UNITS - 1);

	mob_pkg::ctl_state_t state_q, state_d;
	logic [AW-1:0] cnt_q;
	logic          cnt_clr, cnt_inc;
	logic          train_q;
	logic          rsp_valid_q;
	logic          finish;
	logic          last;

	assign last      = (cnt_q == LAST);
	assign addr      = cnt_q;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mob_pkg::ST_CLEAR;
			cnt_q       <= '0;
			train_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) cnt_q <= '0;
			else if (cnt_inc) cnt_q <= cnt_q + AW'(1);
			if (req_valid && req_ready) begin
				train_q <= (mob_pkg::req_op_t'(req_op) == mob_pkg::REQ_TRAIN);
			end
			if (finish) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = mob_pkg::OP_NOP;
		req_ready = 1'b0;
		cnt_clr   = 1'b0;
		cnt_inc   = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			mob_pkg::ST_CLEAR: begin
				cmd = mob_pkg::OP_CLEAR;
				if (last) begin
					cnt_clr = 1'b1;
					state_d = mob_pkg::ST_IDLE;
				end else begin
					cnt_inc = 1'b1;
				end
			end
			mob_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd     = mob_pkg::OP_LOAD;
					cnt_clr = 1'b1;
					unique case (mob_pkg::req_op_t'(req_op))
						mob_pkg::REQ_INFER, mob_pkg::REQ_TRAIN: state_d = mob_pkg::ST_F0;
						mob_pkg::REQ_WRITE: state_d = mob_pkg::ST_WRITE;
						mob_pkg::REQ_READ:  state_d = mob_pkg::ST_RD_ADDR;
						default:            state_d = mob_pkg::ST_IDLE;
					endcase
				end
			end
			mob_pkg::ST_WRITE: begin
				cmd     = mob_pkg::OP_WRITE;
				state_d = mob_pkg::ST_FINISH;
			end
			mob_pkg::ST_RD_ADDR: begin
				cmd     = mob_pkg::OP_RD_ADDR;
				state_d = mob_pkg::ST_RD_TAKE;
			end
			mob_pkg::ST_RD_TAKE: begin
				cmd     = mob_pkg::OP_RD_TAKE;
				state_d = mob_pkg::ST_FINISH;
			end
			mob_pkg::ST_F0: state_d = mob_pkg::ST_F1;
			mob_pkg::ST_F1: begin
				cmd     = mob_pkg::OP_MUL_W0L;
				state_d = mob_pkg::ST_F2;
			end
			mob_pkg::ST_F2: begin
				cmd     = mob_pkg::OP_MUL_W1R;
				state_d = mob_pkg::ST_F3;
			end
			mob_pkg::ST_F3: begin
				cmd     = mob_pkg::OP_ADD_P;
				state_d = mob_pkg::ST_F4;
			end
			mob_pkg::ST_F4: begin
				cmd     = mob_pkg::OP_SIG_IDX;
				state_d = mob_pkg::ST_F5;
			end
			mob_pkg::ST_F5: begin
				cmd     = mob_pkg::OP_MUL_INTERP;
				state_d = mob_pkg::ST_F6;
			end
			mob_pkg::ST_F6: begin
				cmd     = mob_pkg::OP_SIG_OUT;
				state_d = mob_pkg::ST_F7;
			end
			mob_pkg::ST_F7: begin
				cmd     = mob_pkg::OP_MUL_HV;
				state_d = mob_pkg::ST_F8;
			end
			mob_pkg::ST_F8: begin
				cmd = mob_pkg::OP_ACC;
				if (last) begin
					cnt_clr = 1'b1;
					state_d = mob_pkg::ST_FWD_DONE;
				end else begin
					cnt_inc = 1'b1;
					state_d = mob_pkg::ST_F0;
				end
			end
			mob_pkg::ST_FWD_DONE: begin
				cmd     = mob_pkg::OP_FWD_DONE;
				state_d = train_q ? mob_pkg::ST_T0 : mob_pkg::ST_FINISH;
			end
			mob_pkg::ST_T0: state_d = mob_pkg::ST_T1;
			mob_pkg::ST_T1: begin
				cmd     = mob_pkg::OP_MUL_EH;
				state_d = mob_pkg::ST_T2;
			end
			mob_pkg::ST_T2: begin
				cmd     = mob_pkg::OP_TAKE;
				state_d = mob_pkg::ST_T3;
			end
			mob_pkg::ST_T3: begin
				cmd     = mob_pkg::OP_MUL_TLR;
				state_d = mob_pkg::ST_T4;
			end
			mob_pkg::ST_T4: begin
				cmd     = mob_pkg::OP_UPD_V;
				state_d = mob_pkg::ST_T5;
			end
			mob_pkg::ST_T5: begin
				cmd     = mob_pkg::OP_MUL_DERIV;
				state_d = mob_pkg::ST_T6;
			end
			mob_pkg::ST_T6: begin
				cmd     = mob_pkg::OP_MUL_EV;
				state_d = mob_pkg::ST_T7;
			end
			mob_pkg::ST_T7: begin
				cmd     = mob_pkg::OP_TAKE_A;
				state_d = mob_pkg::ST_T8;
			end
			mob_pkg::ST_T8: begin
				cmd     = mob_pkg::OP_MUL_AD;
				state_d = mob_pkg::ST_T9;
			end
			mob_pkg::ST_T9: begin
				cmd     = mob_pkg::OP_TAKE;
				state_d = mob_pkg::ST_T10;
			end
			mob_pkg::ST_T10: begin
				cmd     = mob_pkg::OP_MUL_TLR;
				state_d = mob_pkg::ST_T11;
			end
			mob_pkg::ST_T11: begin
				cmd     = mob_pkg::OP_TAKE;
				state_d = mob_pkg::ST_T12;
			end
			mob_pkg::ST_T12: begin
				cmd     = mob_pkg::OP_MUL_CL;
				state_d = mob_pkg::ST_T13;
			end
			mob_pkg::ST_T13: begin
				cmd     = mob_pkg::OP_UPD_W0;
				state_d = mob_pkg::ST_T14;
			end
			mob_pkg::ST_T14: begin
				cmd = mob_pkg::OP_UPD_W1;
				if (last) begin
					cnt_clr = 1'b1;
					state_d = mob_pkg::ST_FINISH;
				end else begin
					cnt_inc = 1'b1;
					state_d = mob_pkg::ST_T0;
				end
			end
			mob_pkg::ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd     = mob_pkg::OP_FINISH;
					finish  = 1'b1;
					state_d = mob_pkg::ST_IDLE;
				end
			end
			default: state_d = mob_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ rtl/core/mob_datapath.sv @@
module mob_datapath #(
	parameter int HIDDEN_UNITS = mob_pkg::HIDDEN_UNITS_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  mob_pkg::dp_op_t                                    cmd,
	input  logic [((HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1)-1:0] addr,
	input  logic                                               cfg_we,
	input  logic [mob_pkg::STEP_W-1:0]                         cfg_wdata,
	input  logic signed [31:0]                                 left_operand,
	input  logic signed [31:0]                                 right_operand,
	input  logic signed [31:0]                                 target_sum,
	input  logic [mob_pkg::IDX_W-1:0]                          weight_index,
	input  logic signed [31:0]                                 weight_value,
	output logic signed [31:0]                                 network_output,
	output logic signed [31:0]                                 weight_data
);

	localparam int AW      = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam int AccW    = 34 + $clog2(HIDDEN_UNITS);
	localparam int IdxExtW = mob_pkg::IDX_W + $clog2(3 * HIDDEN_UNITS) + 1;
	localparam int SigIdxW = $clog2(mob_pkg::SIG_ENTRIES + 1);
	localparam int PosW    = 28 + SigIdxW;
	localparam logic [IdxExtW-1:0] Nu1 = IdxExtW'(HIDDEN_UNITS);
	localparam logic [IdxExtW-1:0] Nu2 = IdxExtW'(2 * HIDDEN_UNITS);
	localparam logic [IdxExtW-1:0] Nu3 = IdxExtW'(3 * HIDDEN_UNITS);
	localparam logic [SigIdxW-1:0] SigLast = SigIdxW'(mob_pkg::SIG_ENTRIES);
	localparam logic [SigIdxW-1:0] SigTop  = SigIdxW'(mob_pkg::SIG_ENTRIES - 1);

	// request fields and decoded weight select
	logic signed [31:0] l_q, r_q, t_q, wv_q;
	mob_pkg::wsel_t     sel_q, sel_d;
	logic [AW-1:0]      daddr_q, daddr_d;
	logic [mob_pkg::STEP_W-1:0] step_q;

	// working registers
	logic signed [65:0]     prod_q;
	logic signed [39:0]     p_q;
	logic [24:0]            lo_q, h_q;
	logic signed [25:0]     diff_q;
	logic [27:0]            frac_q;
	logic signed [AccW-1:0] acc_q;
	logic signed [31:0]     net_q, e_q, data_q, tmp_q, vn_q;
	logic [22:0]            deriv_q;

	// memory ports
	logic [31:0] w0_rd, w1_rd, v_rd;
	logic [24:0] h_rd;
	logic [AW-1:0] raddr, waddr;
	logic w0_we, w1_we, v_we, h_we;
	logic [31:0] w0_wd, w1_wd, v_wd;

	// combinational results
	logic [IdxExtW-1:0]  idx_e, off;
	logic signed [32:0]  ma, mb;
	logic signed [65:0]  prod_d;
	logic signed [41:0]  sh24;
	logic signed [26:0]  sh28;
	logic signed [31:0]  v_new, w0_new, w1_new, net_d, e_d;
	logic [24:0]         lo_d, hi_d;
	logic signed [25:0]  diff_d;
	logic [27:0]         frac_d, u;
	logic [PosW-1:0]     pos;
	logic [SigIdxW-1:0]  sidx;
	logic signed [26:0]  h_sum;
	logic [24:0]         h_next;

	assign sh24 = prod_q[65:24];
	assign sh28 = prod_q[54:28];

	// weight index decode
	always_comb begin
		idx_e = IdxExtW'(weight_index);
		if (idx_e < Nu1) begin
			sel_d = mob_pkg::WS_W0;
			off   = idx_e;
		end else if (idx_e < Nu2) begin
			sel_d = mob_pkg::WS_W1;
			off   = idx_e - Nu1;
		end else if (idx_e < Nu3) begin
			sel_d = mob_pkg::WS_V;
			off   = idx_e - Nu2;
		end else begin
			sel_d = mob_pkg::WS_NONE;
			off   = '0;
		end
		daddr_d = off[AW-1:0];
	end

	// sigmoid table lookup with clamp outside [-8, 8)
	always_comb begin
		u      = {~p_q[27], p_q[26:0]};
		pos    = PosW'(u) * PosW'(mob_pkg::SIG_ENTRIES);
		sidx   = pos[PosW-1:28];
		frac_d = pos[27:0];
		if (sidx > SigTop) sidx = SigTop;
		lo_d   = mob_pkg::SIG_TAB[sidx];
		hi_d   = mob_pkg::SIG_TAB[sidx + SigIdxW'(1)];
		if (p_q < mob_pkg::SIG_LO) begin
			lo_d   = mob_pkg::SIG_TAB[0];
			hi_d   = mob_pkg::SIG_TAB[0];
			frac_d = '0;
		end else if (p_q >= mob_pkg::SIG_HI) begin
			lo_d   = mob_pkg::SIG_TAB[SigLast];
			hi_d   = mob_pkg::SIG_TAB[SigLast];
			frac_d = '0;
		end
		diff_d = $signed({1'b0, hi_d}) - $signed({1'b0, lo_d});
	end

	assign h_sum  = $signed({2'b00, lo_q}) + sh28;
	assign h_next = h_sum[24:0];

	assign v_new  = mob_pkg::sat32(48'($signed(v_rd)) - 48'(sh24));
	assign w0_new = mob_pkg::sat32(48'($signed(w0_rd)) - 48'(sh24));
	assign w1_new = mob_pkg::sat32(48'($signed(w1_rd)) - 48'(sh24));
	assign net_d  = mob_pkg::sat32(48'(acc_q));
	assign e_d    = mob_pkg::sat32(48'(net_d) - 48'(t_q));

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd)
			mob_pkg::OP_MUL_W0L: begin
				ma = 33'($signed(w0_rd));
				mb = 33'(l_q);
			end
			mob_pkg::OP_MUL_W1R: begin
				ma = 33'($signed(w1_rd));
				mb = 33'(r_q);
			end
			mob_pkg::OP_MUL_INTERP: begin
				ma = 33'(diff_q);
				mb = $signed({5'b0, frac_q});
			end
			mob_pkg::OP_MUL_HV: begin
				ma = $signed({8'b0, h_q});
				mb = 33'($signed(v_rd));
			end
			mob_pkg::OP_MUL_EH: begin
				ma = 33'(e_q);
				mb = $signed({8'b0, h_rd});
			end
			mob_pkg::OP_MUL_TLR: begin
				ma = 33'(tmp_q);
				mb = $signed({9'b0, step_q});
			end
			mob_pkg::OP_MUL_DERIV: begin
				ma = $signed({8'b0, h_rd});
				mb = $signed({8'b0, mob_pkg::ONE_Q24 - h_rd});
			end
			mob_pkg::OP_MUL_EV: begin
				ma = 33'(e_q);
				mb = 33'(vn_q);
			end
			mob_pkg::OP_MUL_AD: begin
				ma = 33'(tmp_q);
				mb = $signed({10'b0, deriv_q});
			end
			mob_pkg::OP_MUL_CL: begin
				ma = 33'(tmp_q);
				mb = 33'(l_q);
			end
			mob_pkg::OP_UPD_W0: begin
				ma = 33'(tmp_q);
				mb = 33'(r_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod_d = ma * mb;

	// memory write and read control
	always_comb begin
		raddr = (cmd == mob_pkg::OP_RD_ADDR) ? daddr_q : addr;
		waddr = (cmd == mob_pkg::OP_WRITE) ? daddr_q : addr;
		w0_we = 1'b0;
		w1_we = 1'b0;
		v_we  = 1'b0;
		h_we  = (cmd == mob_pkg::OP_SIG_OUT);
		w0_wd = '0;
		w1_wd = '0;
		v_wd  = '0;
		case (cmd)
			mob_pkg::OP_CLEAR: begin
				w0_we = 1'b1;
				w1_we = 1'b1;
				v_we  = 1'b1;
			end
			mob_pkg::OP_WRITE: begin
				w0_we = (sel_q == mob_pkg::WS_W0);
				w1_we = (sel_q == mob_pkg::WS_W1);
				v_we  = (sel_q == mob_pkg::WS_V);
				w0_wd = wv_q;
				w1_wd = wv_q;
				v_wd  = wv_q;
			end
			mob_pkg::OP_UPD_V: begin
				v_we = 1'b1;
				v_wd = v_new;
			end
			mob_pkg::OP_UPD_W0: begin
				w0_we = 1'b1;
				w0_wd = w0_new;
			end
			mob_pkg::OP_UPD_W1: begin
				w1_we = 1'b1;
				w1_wd = w1_new;
			end
			default: begin
				w0_we = 1'b0;
			end
		endcase
	end

	mob_ram #(.WIDTH(32), .DEPTH(HIDDEN_UNITS)) u_w0_ram (
		.clk(clk), .we(w0_we), .waddr(waddr), .wdata(w0_wd), .raddr(raddr), .rdata(w0_rd)
	);
	mob_ram #(.WIDTH(32), .DEPTH(HIDDEN_UNITS)) u_w1_ram (
		.clk(clk), .we(w1_we), .waddr(waddr), .wdata(w1_wd), .raddr(raddr), .rdata(w1_rd)
	);
	mob_ram #(.WIDTH(32), .DEPTH(HIDDEN_UNITS)) u_v_ram (
		.clk(clk), .we(v_we), .waddr(waddr), .wdata(v_wd), .raddr(raddr), .rdata(v_rd)
	);
	mob_ram #(.WIDTH(25), .DEPTH(HIDDEN_UNITS)) u_h_ram (
		.clk(clk), .we(h_we), .waddr(addr), .wdata(h_next), .raddr(addr), .rdata(h_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mob_pkg::STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (cmd)
			mob_pkg::OP_LOAD: begin
				l_q     <= left_operand;
				r_q     <= right_operand;
				t_q     <= target_sum;
				wv_q    <= weight_value;
				sel_q   <= sel_d;
				daddr_q <= daddr_d;
				net_q   <= '0;
				data_q  <= '0;
				acc_q   <= '0;
			end
			mob_pkg::OP_RD_TAKE: begin
				case (sel_q)
					mob_pkg::WS_W0: data_q <= w0_rd;
					mob_pkg::WS_W1: data_q <= w1_rd;
					mob_pkg::WS_V:  data_q <= v_rd;
					default:        data_q <= '0;
				endcase
			end
			mob_pkg::OP_MUL_W1R: p_q <= sh24[39:0];
			mob_pkg::OP_ADD_P:   p_q <= p_q + sh24[39:0];
			mob_pkg::OP_SIG_IDX: begin
				lo_q   <= lo_d;
				diff_q <= diff_d;
				frac_q <= frac_d;
			end
			mob_pkg::OP_SIG_OUT: h_q <= h_next;
			mob_pkg::OP_ACC:     acc_q <= acc_q + AccW'(sh24);
			mob_pkg::OP_FWD_DONE: begin
				net_q <= net_d;
				e_q   <= e_d;
			end
			mob_pkg::OP_TAKE:    tmp_q <= sh24[31:0];
			mob_pkg::OP_UPD_V:   vn_q <= v_new;
			mob_pkg::OP_MUL_EV:  deriv_q <= sh24[22:0];
			mob_pkg::OP_TAKE_A:  tmp_q <= mob_pkg::sat32(48'(sh24));
			mob_pkg::OP_FINISH: begin
				network_output <= net_q;
				weight_data    <= data_q;
			end
			default: begin
				net_q <= net_q;
			end
		endcase
	end

endmodule

@@ rtl/core/mlp_online_backprop_step_core.sv @@
// Channel  Side  Handshake        Carries
// req      in    valid / ready    operation, left_operand, right_operand, target_sum,
//                                 weight_index, weight_value
// rsp      out   valid / ready    network_output, weight_data
// cfg      in    cfg_we           cfg_wdata (step size, Q0.24)
//
// Request timing is set by the one shared 33x33 multiplier: the products of a hidden
// unit are formed one after another, and each result is registered before the next use.
// After reset a clearing pass over the N hidden units zeroes all weights; req.ready stays low.
// A finished result sits in the output register while the next request is taken;
// the block only waits at the end of a request if that register is still full.
module mlp_online_backprop_step_core #(
	parameter int HIDDEN_UNITS = mob_pkg::HIDDEN_UNITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mob_pkg::STEP_W-1:0] cfg_wdata,
	mob_req_if.sink                    req,
	mob_rsp_if.source                  rsp
);

	localparam int AW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;

	// command from the sequencer to the datapath, one per cycle
	mob_pkg::dp_op_t cmd;
	// hidden unit address, walked by the sequencer for clear, forward and update
	logic [AW-1:0]   addr;

	// Sequencer: clearing pass, request decode, per-unit micro-steps for the
	// forward pass and the fused output/input weight update, result hand-off.
	mob_ctrl #(.HIDDEN_UNITS(HIDDEN_UNITS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.operation),
		.rsp_ready (rsp.ready),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd),
		.addr      (addr)
	);

	// Datapath: weight and activation memories, the shared multiplier, the
	// sigmoid table with interpolation, accumulator and the result register.
	mob_datapath #(.HIDDEN_UNITS(HIDDEN_UNITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.addr           (addr),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.left_operand   (req.left_operand),
		.right_operand  (req.right_operand),
		.target_sum     (req.target_sum),
		.weight_index   (req.weight_index),
		.weight_value   (req.weight_value),
		.network_output (rsp.network_output),
		.weight_data    (rsp.weight_data)
	);

`ifndef SYNTHESIS
	// a taken request leaves req.ready low in the cycle after
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous one in flight");

	// at most one result field carries data
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.network_output == 32'sd0 || rsp.weight_data == 32'sd0))
		else $error("both result fields non-zero");

	// no request is taken during the clearing pass
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == mob_pkg::OP_CLEAR |-> !req.ready)
		else $error("request ready during weight clear");
`endif

endmodule

@@ dv/mlp_online_backprop_step_core_tb.sv @@
module mlp_online_backprop_step_core_tb;

	localparam int N          = mob_pkg::HIDDEN_UNITS_DEF;
	localparam int NUM_PHASES = 5;
	localparam int PHASE_REQS = 300;
	localparam int CYCLE_CAP  = 30_000_000;
	localparam longint Q24    = 64'sd16777216;
	localparam longint HALF   = 64'sd134217728;

	// one request as driven on the req channel
	typedef struct {
		mob_pkg::req_op_t   op;
		logic signed [31:0] l;
		logic signed [31:0] r;
		logic signed [31:0] t;
		logic [8:0]         idx;
		logic signed [31:0] wv;
	} mlp_req_t;

	typedef struct {
		logic signed [31:0] net;
		logic signed [31:0] data;
	} mlp_rsp_t;

	// directed row: typed = 1 means the answer is written in the row
	typedef struct {
		mlp_req_t rq;
		bit       typed;
		mlp_rsp_t ans;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mob_pkg::STEP_W-1:0] cfg_wdata;

	mob_req_if req_i ();
	mob_rsp_if rsp_i ();

	mlp_online_backprop_step_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_i.sink),
		.rsp       (rsp_i.source)
	);

	// --- shadow copy of the network ---
	longint sig_lut [mob_pkg::SIG_ENTRIES+1];
	longint w_in [2*N];
	longint v_out [N];
	longint h_act [N];
	longint lr_shadow;

	mlp_rsp_t pending_results [$];
	dir_row_t dir_rows [$];

	int  errors;
	int  mismatches;
	int  n_reqs;
	int  n_train;
	int  n_rsp;
	longint cycles;
	bit  quiet;        // no idling on either side
	bit  long_hold;    // ask the receiver for one long stall

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic longint mulq(longint a, longint b);
		return (a * b) >>> 24;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// e^-f, both Q30, truncated Taylor series
	function automatic longint unsigned exp_q30(longint unsigned f);
		longint unsigned term, pos, neg;
		term = 64'd1 << 30;
		pos  = 64'd1 << 30;
		neg  = 0;
		for (int n = 1; n <= 20; n++) begin
			term = ((term * f) >> 30) / longint'(n);
			if (n % 2 == 1) neg += term;
			else pos += term;
		end
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

	function automatic longint lut_point(longint x);
		longint unsigned m, y, d, s;
		m = (x < 0) ? -x : x;
		y = exp_q30(m * 8);
		for (int i = 0; i < 3; i++) y = (y * y) >> 30;
		d = (64'd1 << 30) + y;
		s = ((64'd1 << 54) + (d >> 1)) / d;
		return (x < 0) ? Q24 - longint'(s) : longint'(s);
	endfunction

	function automatic longint sigmoid_q24(longint x);
		longint u, p, k, fr, lo, hi;
		if (x < -HALF) return sig_lut[0];
		if (x >= HALF) return sig_lut[mob_pkg::SIG_ENTRIES];
		u  = x + HALF;
		p  = u * mob_pkg::SIG_ENTRIES;
		k  = p >>> 28;
		fr = p & ((64'sd1 << 28) - 1);
		if (k >= mob_pkg::SIG_ENTRIES) k = mob_pkg::SIG_ENTRIES - 1;
		lo = sig_lut[k];
		hi = sig_lut[k+1];
		return lo + (((hi - lo) * fr) >>> 28);
	endfunction

	// forward pass, and the SGD update on train; weight write or read otherwise
	function automatic mlp_rsp_t network_step(mlp_req_t rq);
		mlp_rsp_t res;
		longint l, r, acc, e, d, dv, a, c;
		l = rq.l;
		r = rq.r;
		res.net  = '0;
		res.data = '0;
		if (rq.op == mob_pkg::REQ_INFER || rq.op == mob_pkg::REQ_TRAIN) begin
			acc = 0;
			for (int i = 0; i < N; i++) begin
				h_act[i] = sigmoid_q24(mulq(w_in[i], l) + mulq(w_in[N+i], r));
				acc += mulq(h_act[i], v_out[i]);
			end
			res.net = 32'(clamp32(acc));
			if (rq.op == mob_pkg::REQ_TRAIN) begin
				e = clamp32(longint'(res.net) - longint'(rq.t));
				for (int i = 0; i < N; i++) begin
					d = mulq(e, h_act[i]);
					v_out[i] = clamp32(v_out[i] - mulq(lr_shadow, d));
				end
				// input layer sees the freshly updated output weights
				for (int i = 0; i < N; i++) begin
					dv = mulq(h_act[i], Q24 - h_act[i]);
					a  = clamp32(mulq(e, v_out[i]));
					c  = mulq(mulq(a, dv), lr_shadow);
					w_in[i]   = clamp32(w_in[i] - mulq(c, l));
					w_in[N+i] = clamp32(w_in[N+i] - mulq(c, r));
				end
			end
		end else if (rq.idx < 3*N) begin
			if (rq.op == mob_pkg::REQ_WRITE) begin
				if (rq.idx < 2*N) w_in[rq.idx] = rq.wv;
				else v_out[rq.idx-2*N] = rq.wv;
			end else begin
				res.data = (rq.idx < 2*N) ? 32'(w_in[rq.idx]) : 32'(v_out[rq.idx-2*N]);
			end
		end
		return res;
	endfunction

	// mostly moderate values so the sigmoid works in its middle; some full-scale
	function automatic logic signed [31:0] rand_q(int scale_bits);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) return $signed($urandom_range(0, (1 << (scale_bits+1)) - 1))
			- (32'sd1 <<< scale_bits);
		if (sel < 9) return $signed($urandom_range(0, (1 << 29) - 1)) - 32'sd268435456;
		return $urandom;
	endfunction

	function automatic mlp_req_t rand_req();
		mlp_req_t rq;
		rq.op  = mob_pkg::req_op_t'($urandom_range(0, 3));
		rq.l   = rand_q(25);
		rq.r   = rand_q(25);
		rq.t   = rand_q(26);
		rq.wv  = rand_q(24);
		// out-of-range indexes now and then
		rq.idx = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
			: 9'($urandom_range(0, 3*N-1));
		return rq;
	endfunction

	// present one request and hold it until taken; expectation logged on accept
	task automatic send_req(mlp_req_t rq, bit typed, mlp_rsp_t ans);
		mlp_rsp_t pred;
		req_i.valid         <= 1'b1;
		req_i.operation     <= rq.op;
		req_i.left_operand  <= rq.l;
		req_i.right_operand <= rq.r;
		req_i.target_sum    <= rq.t;
		req_i.weight_index  <= rq.idx;
		req_i.weight_value  <= rq.wv;
		do @(posedge clk); while (!req_i.ready);
		pred = network_step(rq);
		pending_results.insert(pending_results.size(), typed ? ans : pred);
		n_reqs++;
		if (rq.op == mob_pkg::REQ_TRAIN) n_train++;
		// random sender gap
		if (!quiet && $urandom_range(0, 7) == 0) begin
			req_i.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// withdraw the request line, then wait for every outstanding result
	task automatic drain();
		req_i.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// block must be idle: called after drain(), or before the first request is sent
	task automatic set_step(logic [mob_pkg::STEP_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		lr_shadow = v;
	endtask

	task automatic add_row(mob_pkg::req_op_t op, logic signed [31:0] l,
		logic signed [31:0] r, logic signed [31:0] t, logic [8:0] idx,
		logic signed [31:0] wv, bit typed,
		logic signed [31:0] net, logic signed [31:0] data);
		dir_row_t row;
		row.rq.op    = op;
		row.rq.l     = l;
		row.rq.r     = r;
		row.rq.t     = t;
		row.rq.idx   = idx;
		row.rq.wv    = wv;
		row.typed    = typed;
		row.ans.net  = net;
		row.ans.data = data;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// receiver: random stalls, plus one long stall on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold  = 1'b0;
				stall_left = 600;
			end
			if (stall_left > 0) begin
				rsp_i.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				rsp_i.ready <= 1'b0;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				rsp_i.ready <= 1'b1;
			end
		end
	end

	// result checker: oldest expectation first
	always @(posedge clk) begin
		mlp_rsp_t exp_r;
		if (arst_n && rsp_i.valid && rsp_i.ready) begin
			n_rsp++;
			if (pending_results.size() == 0) begin
				errors++;
				if (mismatches < 10)
					$display("unexpected response net=%h data=%h",
						rsp_i.network_output, rsp_i.weight_data);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_i.network_output !== exp_r.net || rsp_i.weight_data !== exp_r.data) begin
					errors++;
					if (mismatches < 10)
						$display("mismatch #%0d: net exp %h got %h, data exp %h got %h",
							n_rsp, exp_r.net, rsp_i.network_output,
							exp_r.data, rsp_i.weight_data);
					mismatches++;
				end
			end
		end
	end

	initial begin
		mlp_rsp_t none;
		mlp_req_t rq;
		logic [mob_pkg::STEP_W-1:0] steps [NUM_PHASES];

		clk        = 1'b0;
		errors     = 0;
		mismatches = 0;
		n_reqs     = 0;
		n_train    = 0;
		n_rsp      = 0;
		cycles     = 0;
		quiet      = 1'b0;
		long_hold  = 1'b0;
		none.net   = '0;
		none.data  = '0;

		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		req_i.valid         <= 1'b0;
		req_i.operation     <= mob_pkg::REQ_INFER;
		req_i.left_operand  <= '0;
		req_i.right_operand <= '0;
		req_i.target_sum    <= '0;
		req_i.weight_index  <= '0;
		req_i.weight_value  <= '0;
		rsp_i.ready         <= 1'b0;

		for (int k = 0; k <= mob_pkg::SIG_ENTRIES; k++)
			sig_lut[k] = lut_point(-HALF + ((longint'(k) << 28) / mob_pkg::SIG_ENTRIES));
		for (int i = 0; i < 2*N; i++) w_in[i] = 0;
		for (int i = 0; i < N; i++) begin
			v_out[i] = 0;
			h_act[i] = 0;
		end
		lr_shadow = mob_pkg::STEP_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, index edges, saturating inputs, sigmoid tails
		add_row(mob_pkg::REQ_INFER, 32'sh01000000, -32'sh01000000, 0, 0, 0, 1, 0, 0);
		add_row(mob_pkg::REQ_READ,  0, 0, 0, 9'd0,   0, 1, 0, 0);
		add_row(mob_pkg::REQ_READ,  0, 0, 0, 9'd383, 0, 1, 0, 0);
		add_row(mob_pkg::REQ_READ,  0, 0, 0, 9'd511, 0, 1, 0, 0);
		add_row(mob_pkg::REQ_WRITE, 0, 0, 0, 9'd0,   32'sh7fffffff, 1, 0, 0);
		add_row(mob_pkg::REQ_READ,  0, 0, 0, 9'd0,   0, 1, 0, 32'sh7fffffff);
		add_row(mob_pkg::REQ_WRITE, 0, 0, 0, 9'd500, 32'sh12345678, 1, 0, 0);
		add_row(mob_pkg::REQ_READ,  0, 0, 0, 9'd500, 0, 1, 0, 0);
		add_row(mob_pkg::REQ_WRITE, 0, 0, 0, 9'd128, 32'sh80000000, 1, 0, 0);
		add_row(mob_pkg::REQ_READ,  0, 0, 0, 9'd128, 0, 1, 0, 32'sh80000000);
		add_row(mob_pkg::REQ_WRITE, 0, 0, 0, 9'd256, 32'sh01000000, 1, 0, 0);
		add_row(mob_pkg::REQ_WRITE, 0, 0, 0, 9'd383, -32'sh01000000, 1, 0, 0);
		// pre-activations far past both table ends
		add_row(mob_pkg::REQ_INFER, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0, 0, 0);
		add_row(mob_pkg::REQ_INFER, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0, 0, 0);
		add_row(mob_pkg::REQ_INFER, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(mob_pkg::REQ_TRAIN, 32'sh01000000, -32'sh01000000, 32'sh01000000,
			0, 0, 0, 0, 0);
		add_row(mob_pkg::REQ_TRAIN, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			0, 0, 0, 0, 0);
		add_row(mob_pkg::REQ_INFER, 32'sh00400000, 32'sh00c00000, 0, 0, 0, 0, 0, 0);
		add_row(mob_pkg::REQ_WRITE, 0, 0, 0, 9'd0,   32'sh00800000, 1, 0, 0);
		add_row(mob_pkg::REQ_WRITE, 0, 0, 0, 9'd128, -32'sh00400000, 1, 0, 0);
		add_row(mob_pkg::REQ_TRAIN, 32'sh00800000, 32'sh01800000, -32'sh02000000,
			0, 0, 0, 0, 0);
		add_row(mob_pkg::REQ_READ,  0, 0, 0, 9'd256, 0, 0, 0, 0);
		add_row(mob_pkg::REQ_READ,  0, 0, 0, 9'd383, 0, 0, 0, 0);
		add_row(mob_pkg::REQ_READ,  0, 0, 0, 9'd0,   0, 0, 0, 0);

		set_step(mob_pkg::STEP_RESET);
		foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].ans);

		// step sizes per phase: zero, full scale, random, small, reset value
		steps[0] = '0;
		steps[1] = 24'hffffff;
		steps[2] = 24'($urandom);
		steps[3] = 24'($urandom_range(1, 4096));
		steps[4] = mob_pkg::STEP_RESET;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			set_step(steps[ph]);
			quiet = (ph == NUM_PHASES - 1);
			for (int n = 0; n < PHASE_REQS; n++) begin
				// back-to-back short requests under a long receiver stall
				if (ph == 1 && n == 100) begin
					long_hold = 1'b1;
					for (int k = 0; k < 40; k++) begin
						rq = rand_req();
						rq.op = ($urandom_range(0, 1) == 0) ? mob_pkg::REQ_WRITE
							: mob_pkg::REQ_READ;
						send_req(rq, 0, none);
					end
				end
				// sender waits for the pipe to empty
				if (n == 200) drain();
				send_req(rand_req(), 0, none);
			end
		end

		drain();
		repeat (100) @(posedge clk);

		if (pending_results.size() != 0) errors++;
		$display("%0d requests (%0d training steps), %0d responses, %0d step sizes",
			n_reqs, n_train, n_rsp, NUM_PHASES + 1);
		$display("%0d mismatches, %0d cycles", mismatches, cycles);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
